// ===== rtl/dfft_pkg.sv =====
package dfft_pkg;

   localparam int unsigned FRAME_HALF_BITS = 38;
   localparam logic [5:0]  FRAME_LEN       = 6'd38;

   // register index codes
   localparam logic CSR_HALF_BIT_TICKS = 1'b0;
   localparam logic CSR_INVERT_POLARITY = 1'b1;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SEND = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] address_byte;
      logic [7:0] data_byte;
   } req_data_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic rejected;
   } rsp_data_type;

   typedef logic [FRAME_HALF_BITS-1:0] frame_type;

   // Start bit, address MSB first, data MSB first, two stop symbols (four high halves).
   function automatic frame_type build_frame(input logic [7:0] addr, input logic [7:0] data,
                                             input logic inv);
      logic [16:0] bits;
      frame_type   f;
      bits = {1'b1, addr, data};
      f    = '0;
      for (int i = 0; i < 17; i++) begin
         f[FRAME_HALF_BITS-1-2*i] = bits[16-i] ^ inv;
         f[FRAME_HALF_BITS-2-2*i] = ~(bits[16-i] ^ inv);
      end
      f[3:0] = 4'hF;
      return f;
   endfunction

endpackage

// ===== rtl/dfft_core.sv =====
module dfft_core import dfft_pkg::*; #(
   parameter int unsigned TICK_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  req_data_type          item,
   input  logic [TICK_WIDTH-1:0] half_bit_ticks,
   input  logic                  invert_polarity,
   output rsp_data_type          result
);

   frame_type             shift_ff, shift_in;
   logic [5:0]            left_ff, left_in;
   logic [TICK_WIDTH-1:0] count_ff, count_in;
   logic                  line_ff, line_in;
   logic                  rejected;
   logic                  busy;

   assign busy = (left_ff != 6'd0);

   always_comb begin
      shift_in = shift_ff;
      left_in  = left_ff;
      count_in = count_ff;
      line_in  = line_ff;
      rejected = 1'b0;
      if (item.op == OP_SEND) begin
         if (busy) begin
            rejected = 1'b1;
         end else begin
            shift_in = build_frame(item.address_byte, item.data_byte, invert_polarity);
            left_in  = FRAME_LEN;
            count_in = half_bit_ticks;
         end
      end else if (busy) begin
         if (count_ff > TICK_WIDTH'(1)) begin
            count_in = count_ff - TICK_WIDTH'(1);
         end else begin
            line_in  = shift_ff[FRAME_HALF_BITS-1];
            shift_in = {shift_ff[FRAME_HALF_BITS-2:0], 1'b0};
            left_in  = left_ff - 6'd1;
            count_in = (left_in != 6'd0) ? half_bit_ticks : '0;
         end
      end
   end

   assign result.line_level = line_in;
   assign result.busy_res   = (left_in != 6'd0);
   assign result.rejected   = rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         left_ff  <= 6'd0;
         count_ff <= '0;
         line_ff  <= 1'b1;
      end else if (step) begin
         shift_ff <= shift_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         line_ff  <= line_in;
      end
   end

endmodule

// ===== rtl/dfft_outq.sv =====
module dfft_outq import dfft_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_data_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   rsp_data_type slot_ff [2];
   logic [1:0]   count_ff, count_in;
   logic         wr_ptr_ff, rd_ptr_ff;
   logic         pop;

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

// ===== rtl/dali_forward_frame_transmitter_unit.sv =====
// Path: an accepted transaction is held in the input register, and its result is written
//   into the output queue once the queue has room and shown on rsp_valid from then on.
// Throughput: one transaction per cycle while req_stall is low; the two-entry output queue
//   holds results while the consumer stalls, and req_stall rises only when the input register
//   and queue are full. Reset (synchronous, active high): line idles high, no frame pending,
//   queue empty, half_bit_ticks = 10000 (truncated to TICK_WIDTH), polarity normal.
module dali_forward_frame_transmitter_unit import dfft_pkg::*; #(
   parameter int unsigned TICK_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [TICK_WIDTH-1:0] csr_write_data
);

   localparam logic [TICK_WIDTH-1:0] TICKS_RESET = TICK_WIDTH'(10000);

   // configuration registers
   logic [TICK_WIDTH-1:0] half_bit_ticks_ff;
   logic                  invert_ff;

   // input register
   logic         s1_valid_ff, s1_valid_in;
   req_data_type s1_data_ff;

   logic         req_accept;
   logic         s1_advance;
   logic         q_full;
   rsp_data_type step_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ticks_ff <= TICKS_RESET;
         invert_ff         <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HALF_BIT_TICKS:  half_bit_ticks_ff <= csr_write_data;
            CSR_INVERT_POLARITY: invert_ff         <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Stall only depends on registered state: held item plus full queue.
   assign req_stall  = s1_valid_ff && q_full;
   assign req_accept = req_valid && !req_stall;
   assign s1_advance = s1_valid_ff && !q_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
   end

   // Frame state: countdown, half-bit shifter, line level
   dfft_core #(
      .TICK_WIDTH(TICK_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (s1_advance),
      .item           (s1_data_ff),
      .half_bit_ticks (half_bit_ticks_ff),
      .invert_polarity(invert_ff),
      .result         (step_result)
   );

   dfft_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (s1_advance),
      .push_data(step_result),
      .full     (q_full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // a refusal only happens with a frame in flight, which stays in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> rsp_data.busy_res)
      else $error("rejected result without busy");

   // stall implies an item is held in the input register and a result is presented
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid)
      else $error("stall without held transaction");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid_ff)
      else $error("result present after reset");

endmodule

// ===== test/dali_forward_frame_transmitter_unit_tb.sv =====
module dali_forward_frame_transmitter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dfft_pkg::*;

   localparam int TICK_W        = 24;
   // cycles to let pass after the last result before touching registers or ending
   localparam int SETTLE_CYCLES = 4;
   // items per half of one random phase (idle ticks are not counted)
   localparam int HALF_PHASE    = 69;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // block ports, all inputs at known values from time zero
   logic                req_valid        = 1'b0;
   logic                req_stall;
   req_data_type        req_data         = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   rsp_data_type        rsp_data;
   logic                csr_write_enable = 1'b0;
   logic                csr_index        = CSR_HALF_BIT_TICKS;
   logic [TICK_W-1:0]   csr_write_data   = '0;

   dali_forward_frame_transmitter_unit #(
      .TICK_WIDTH (TICK_W)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------------
   // Transmitter shadow: register copies plus frame state, advanced once per
   // accepted transaction, in acceptance order.
   // ---------------------------------------------------------------------------
   logic [TICK_W-1:0] ticks_per_half = TICK_W'(10000);
   logic              invert_pol     = 1'b0;

   frame_type         pending_halves = '0;   // next half-bit to drive sits in the MSB
   logic [5:0]        halves_left    = '0;
   logic [TICK_W-1:0] ticks_left     = '0;
   logic              line_q         = 1'b1; // line idles high

   // expected line/busy/rejected, oldest first
   rsp_data_type      expected_line_states[$];

   int unsigned       mismatch_count = 0;
   int unsigned       results_seen   = 0;
   int unsigned       counted_items  = 0;   // transactions that do more than idle

   // idle and stall rates in percent
   int unsigned       req_gap_pct    = 0;
   int unsigned       rsp_stall_pct  = 0;

   // Manchester coding of start bit, address and data, then four high stop halves.
   // Polarity is applied at load time only.
   function automatic frame_type code_frame(input logic [7:0] addr, input logic [7:0] data);
      logic [16:0] symbols;
      frame_type   f;
      logic        first_half;
      symbols = {1'b1, addr, data};
      f       = '0;
      for (int k = 16; k >= 0; k--) begin
         first_half = symbols[k] ^ invert_pol;
         f = {f[FRAME_HALF_BITS-3:0], first_half, ~first_half};
      end
      f = {f[FRAME_HALF_BITS-5:0], 4'hF};
      return f;
   endfunction

   function automatic rsp_data_type step_transmitter(input req_data_type item);
      rsp_data_type r;
      r = '0;
      if (item.op == OP_SEND) begin
         if (halves_left != 0) begin
            // refused; the frame in flight carries on untouched
            r.rejected = 1'b1;
         end else begin
            pending_halves = code_frame(item.address_byte, item.data_byte);
            halves_left    = FRAME_LEN;
            ticks_left     = ticks_per_half;
         end
      end else if (halves_left != 0) begin
         // a zero tick setting behaves like one: the compare below shifts right away
         if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
         end else begin
            line_q         = pending_halves[FRAME_HALF_BITS-1];
            pending_halves = pending_halves << 1;
            halves_left    = halves_left - 1'b1;
            ticks_left     = (halves_left != 0) ? ticks_per_half : '0;
         end
      end
      r.line_level = line_q;
      r.busy_res   = (halves_left != 0);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("mismatch @%0t, result %0d: %s", $time, results_seen, what);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stall, compare each accepted transaction field by field
   // against the oldest prediction.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_line_states.size() == 0) begin
               report_mismatch("result with no transaction pending");
            end else begin
               want = expected_line_states.pop_front();
               if (rsp_data.line_level !== want.line_level) begin
                  report_mismatch($sformatf("line_level %b, want %b",
                                            rsp_data.line_level, want.line_level));
               end
               if (rsp_data.busy_res !== want.busy_res) begin
                  report_mismatch($sformatf("busy_res %b, want %b",
                                            rsp_data.busy_res, want.busy_res));
               end
               if (rsp_data.rejected !== want.rejected) begin
                  report_mismatch($sformatf("rejected %b, want %b",
                                            rsp_data.rejected, want.rejected));
               end
            end
            results_seen++;
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Drive one transaction, hold it until accepted, then predict its result.
   // req_valid is left high on return so back-to-back transactions need no dip.
   task automatic send_item(input logic op, input logic [7:0] addr, input logic [7:0] data);
      req_data_type item;
      item.op           = op;
      item.address_byte = addr;
      item.data_byte    = data;
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (op == OP_SEND || halves_left != 0) begin
         counted_items++;
      end
      expected_line_states.push_back(step_transmitter(item));
   endtask

   // Tick with random (ignored) byte fields.
   task automatic send_tick();
      send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic tick_until_frame_done();
      while (halves_left != 0) begin
         send_tick();
      end
   endtask

   // Stop sending and wait until every prediction has been matched.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_line_states.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers; only done with no transaction outstanding.
   task automatic configure(input logic [TICK_W-1:0] ticks, input logic invert);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HALF_BIT_TICKS;
      csr_write_data   <= ticks;
      @(posedge clock);
      ticks_per_half = ticks;
      csr_index      <= CSR_INVERT_POLARITY;
      csr_write_data <= TICK_W'(invert);
      @(posedge clock);
      invert_pol = invert;
      csr_write_enable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Ticks with nothing loaded leave the line high and idle; byte fields are don't-care.
   task automatic test_idle_ticks();
      send_item(OP_TICK, 8'hFF, 8'hFF);
      send_item(OP_TICK, 8'h00, 8'h00);
      send_tick();
   endtask

   // All-ones address, all-zeros data at one tick per half; requests refused
   // right after load and on the last half-bit.
   task automatic test_directed_frame();
      configure(TICK_W'(1), 1'b0);
      send_item(OP_SEND, 8'hFF, 8'h00);
      send_item(OP_SEND, 8'h12, 8'h34);
      while (halves_left > 1) begin
         send_tick();
      end
      send_item(OP_SEND, 8'hAB, 8'hCD);
      tick_until_frame_done();
      send_tick();
   endtask

   // Zero tick setting acts as one; inverted polarity; a new frame right after
   // the previous one ends.
   task automatic test_zero_ticks();
      configure('0, 1'b1);
      send_item(OP_SEND, 8'h00, 8'hFF);
      tick_until_frame_done();
      send_item(OP_SEND, 8'h5A, 8'hA5);
      tick_until_frame_done();
   endtask

   // Polarity and tick count change while a frame is in flight: coding stays,
   // the new count applies from the next reload.
   task automatic test_polarity_change();
      configure(TICK_W'(2), 1'b0);
      send_item(OP_SEND, 8'hC3, 8'h81);
      repeat (7) send_tick();
      configure(TICK_W'(3), 1'b1);
      tick_until_frame_done();
      send_item(OP_SEND, 8'hC3, 8'h81);
      tick_until_frame_done();
   endtask

   // Mostly whole frames with random bytes, some idle ticks and some refused
   // requests; four idle/stall profiles, each with a full drain half way.
   task automatic test_random_frames();
      int unsigned gap_pct[4]   = '{0, 87, 0, 37};
      int unsigned stall_pct[4] = '{0, 0, 87, 37};
      int unsigned choice;
      int unsigned phase_start;
      for (int p = 0; p < 4; p++) begin
         configure(TICK_W'($urandom_range(1, 3)), 1'($urandom_range(1)));
         req_gap_pct   = gap_pct[p];
         rsp_stall_pct = stall_pct[p];
         for (int h = 0; h < 2; h++) begin
            phase_start = counted_items;
            while (counted_items - phase_start < HALF_PHASE) begin
               choice = $urandom_range(99);
               if (halves_left == 0) begin
                  if (choice < 80) begin
                     send_item(OP_SEND, 8'($urandom_range(255)), 8'($urandom_range(255)));
                  end else begin
                     send_tick();
                  end
               end else if (choice < 5) begin
                  send_item(OP_SEND, 8'($urandom_range(255)), 8'($urandom_range(255)));
               end else begin
                  send_tick();
               end
            end
            // sender holds off until everything outstanding has come back
            wait_idle();
         end
      end
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
   endtask

   // Largest tick count: the countdown runs from the top of its range and the
   // frame cannot finish within the run, so this goes last.
   task automatic test_max_ticks();
      configure('1, 1'b0);
      send_item(OP_SEND, 8'hA5, 8'h5A);
      repeat (20) send_tick();
      send_item(OP_SEND, 8'h0F, 8'hF0);
      send_tick();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_ticks();
      test_directed_frame();
      test_zero_ticks();
      test_polarity_change();
      test_random_frames();
      test_max_ticks();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_line_states.size() == 0) begin
         $display("[dali_forward_frame_transmitter_unit] OK");
      end else begin
         $display("[dali_forward_frame_transmitter_unit] ERROR");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #1_000_000;
      $display("[dali_forward_frame_transmitter_unit] ERROR");
      $finish;
   end

endmodule

// ===== dali_forward_frame_transmitter_unit.f =====
rtl/dfft_pkg.sv
rtl/dfft_core.sv
rtl/dfft_outq.sv
rtl/dali_forward_frame_transmitter_unit.sv
test/dali_forward_frame_transmitter_unit_tb.sv
